### hdl/lru_pinned_page_directory_defines.svh
// Assertion macros for the page directory.
// No dependencies; included by modules that carry assertions.
`ifndef LRU_PINNED_PAGE_DIRECTORY_DEFINES_SVH
`define LRU_PINNED_PAGE_DIRECTORY_DEFINES_SVH
`ifndef SYNTHESIS
`define LPD_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define LPD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
`else
`define LPD_ASSERT_IMPL(label, clk, rst, prop)
`define LPD_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### hdl/lpd_pkg.sv
// Shared types and codes of the page directory.
// No dependencies.
package lpd_pkg;
   localparam int CAPACITY = 16;
   localparam int PIN_BITS = 8;
   localparam int SLOT_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      KIND_FETCH = 3'd0, KIND_NEW = 3'd1, KIND_UNPIN = 3'd2,
      KIND_PUSH = 3'd3, KIND_FLUSH_TBL = 3'd4, KIND_FLUSH_ALL = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      EV_HIT = 3'd0, EV_LOAD = 3'd1, EV_WRITEBACK = 3'd2, EV_EXISTS = 3'd3,
      EV_NOT_FOUND = 3'd4, EV_FULL = 3'd5, EV_DONE = 3'd6
   } event_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [3:0]  slot;
      logic [7:0]  out_table;
      logic [31:0] out_page;
      logic        last;
   } result_type;
endpackage

### hdl/lpd_result_reg.sv
// Output register of the result channel.
// Depends on lpd_pkg.
module lpd_result_reg
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);
   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // hold one result until taken
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_valid && out_ready) valid_in = 1'b0;
      if (push_valid) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      data_ff <= data_in;
   end

   assign full      = valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### hdl/lru_pinned_page_directory.sv
// Page directory of a buffer pool with pin counts and LRU replacement. One
// request is taken at a time, and a sequencer walks the sixteen slots one per
// cycle through a shared compare unit, but waits in a flush scan while the
// output side is busy. Every request goes through a tag lookup over all slots
// and a dispatch. A fetch hit that promotes, and any insert at the most-recent
// end, adds a rank pass. A miss adds a limit check, a search for a free slot
// and an insert. Each eviction takes a limit check, a victim scan, a drop and
// a rank pass. A flush scans all slots once per occupied rank. Each result
// stalls the sequencer until the output register is free again, which takes
// longer while the consumer stalls. The next request is taken once the final
// result has left. The shortest requests are a transient hit, an unpin, or a
// new or push of a present page. The final result of a request has tlast set.
// Depends on lpd_pkg, lpd_result_reg and the defines header.
`include "lru_pinned_page_directory_defines.svh"
module lru_pinned_page_directory
   import lpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // table_id[7:0], page_number[39:8]
   input  logic [4:0]  req_tuser,  // kind[2:0], transient[3], mark_dirty[4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // slot[3:0], out_table[11:4], out_page[43:12],
                                   // zero[47:44]
   output logic [2:0]  rsp_tuser,  // event_res[2:0]
   output logic        rsp_tlast,  // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data    // pool_limit
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOK, ST_DISPATCH, ST_EVCHK, ST_VSCAN, ST_VDROP, ST_ADJ,
      ST_FREE, ST_INS, ST_FSCAN, ST_EMIT_FINAL, ST_WAIT
   } state_type;

   state_type state_ff;
   logic [SLOT_BITS-1:0] idx_ff;
   logic [CNT_BITS-1:0]  rscan_ff;
   logic [2:0]  kind_ff;
   logic [7:0]  tbl_ff;
   logic [31:0] page_ff;
   logic        trans_ff, mark_ff;
   logic        found_ff;
   logic [SLOT_BITS-1:0] hit_ff;
   logic        vfound_ff;
   logic [SLOT_BITS-1:0] vic_ff;
   logic [SLOT_BITS-1:0] ref_rank_ff;
   logic        adj_mode_ff; // 0 promote (inc below), 1 drop (dec above)
   state_type   ret_ff;
   logic [4:0]  limit_ff;
   logic [CNT_BITS-1:0] occ_ff;

   logic [CAPACITY-1:0] valid_ff, dirty_ff;
   logic [PIN_BITS-1:0] pin_ff  [CAPACITY];
   logic [SLOT_BITS-1:0] rank_ff [CAPACITY];
   logic [7:0]  ttab_ff [CAPACITY];
   logic [31:0] tpage_ff[CAPACITY];

   logic       push_valid_ff, full;
   result_type push_data_ff, rsp_data;

   // output side busy: a result is held or on its way in
   logic out_busy;
   assign out_busy = full || push_valid_ff;

   // effective limit
   logic [CNT_BITS-1:0] eff_limit;
   always_comb begin
      if (limit_ff == 5'd0) eff_limit = CNT_BITS'(1);
      else if ({1'b0, limit_ff} > 6'(CAPACITY)) eff_limit = CNT_BITS'(CAPACITY);
      else eff_limit = CNT_BITS'(limit_ff);
   end

   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !full;

   // shared per-slot compare unit
   logic tag_eq;
   assign tag_eq = valid_ff[idx_ff] && ttab_ff[idx_ff] == tbl_ff
                   && tpage_ff[idx_ff] == page_ff;

   // result helper
   function automatic result_type mk(input event_type ev,
                                     input logic [SLOT_BITS-1:0] s,
                                     input logic [7:0] t, input logic [31:0] p,
                                     input logic l);
      result_type r;
      r.event_res = ev;
      r.slot = 4'(s);
      r.out_table = t;
      r.out_page = p;
      r.last = l;
      return r;
   endfunction

   logic last_idx;
   assign last_idx = (idx_ff == SLOT_BITS'(CAPACITY - 1));

   always_ff @(posedge clock) begin
      logic push_now;
      push_now = 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         dirty_ff <= '0;
         occ_ff   <= '0;
         limit_ff <= 5'd16;
         for (int i = 0; i < CAPACITY; i++) begin
            pin_ff[i]  <= '0;
            rank_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) limit_ff <= csr_data;
               if (req_tvalid && req_tready) begin
                  kind_ff  <= req_tuser[2:0];
                  tbl_ff   <= req_tdata[7:0];
                  page_ff  <= req_tdata[39:8];
                  trans_ff <= req_tuser[3];
                  mark_ff  <= req_tuser[4];
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               if (tag_eq && !found_ff) begin
                  found_ff <= 1'b1;
                  hit_ff   <= idx_ff;
               end
               idx_ff <= idx_ff + 1'b1;
               if (last_idx) state_ff <= ST_DISPATCH;
            end
            ST_DISPATCH: begin
               idx_ff <= '0;
               case (kind_ff)
                  KIND_FETCH: begin
                     if (found_ff) begin
                        if (pin_ff[hit_ff] != '1) pin_ff[hit_ff] <= pin_ff[hit_ff] + 1'b1;
                        push_data_ff <= mk(EV_HIT, hit_ff, tbl_ff, page_ff, 1'b1);
                        if (!trans_ff) begin
                           ref_rank_ff <= rank_ff[hit_ff];
                           vic_ff <= hit_ff;
                           adj_mode_ff <= 1'b0;
                           ret_ff <= ST_WAIT;
                           state_ff <= ST_ADJ;
                        end else begin
                           push_now = 1'b1;
                           state_ff <= ST_WAIT;
                        end
                     end else state_ff <= ST_EVCHK;
                  end
                  KIND_NEW: begin
                     if (found_ff) begin
                        push_now = 1'b1;
                        push_data_ff <= mk(EV_EXISTS, hit_ff, tbl_ff, page_ff, 1'b1);
                        state_ff <= ST_WAIT;
                     end else state_ff <= ST_EVCHK;
                  end
                  KIND_UNPIN: begin
                     push_now = 1'b1;
                     if (found_ff) begin
                        if (pin_ff[hit_ff] != '0) pin_ff[hit_ff] <= pin_ff[hit_ff] - 1'b1;
                        if (mark_ff) dirty_ff[hit_ff] <= 1'b1;
                        push_data_ff <= mk(EV_DONE, hit_ff, tbl_ff, page_ff, 1'b1);
                     end else push_data_ff <= mk(EV_NOT_FOUND, '0, tbl_ff, page_ff, 1'b1);
                     state_ff <= ST_WAIT;
                  end
                  KIND_PUSH: begin
                     if (found_ff) begin
                        dirty_ff[hit_ff] <= 1'b1;
                        push_now = 1'b1;
                        push_data_ff <= mk(EV_DONE, hit_ff, tbl_ff, page_ff, 1'b1);
                        state_ff <= ST_WAIT;
                     end else state_ff <= ST_EVCHK;
                  end
                  KIND_FLUSH_TBL, KIND_FLUSH_ALL: begin
                     rscan_ff <= '0;
                     state_ff <= (occ_ff == '0) ? ST_EMIT_FINAL : ST_FSCAN;
                  end
                  default: state_ff <= ST_EMIT_FINAL;
               endcase
            end
            ST_EVCHK: begin
               idx_ff <= '0;
               vfound_ff <= 1'b0;
               if (!out_busy) state_ff <= (occ_ff >= eff_limit) ? ST_VSCAN : ST_FREE;
            end
            ST_VSCAN: begin
               if (valid_ff[idx_ff] && pin_ff[idx_ff] == '0 &&
                   (!vfound_ff || rank_ff[idx_ff] > rank_ff[vic_ff])) begin
                  vfound_ff <= 1'b1;
                  vic_ff <= idx_ff;
               end
               idx_ff <= idx_ff + 1'b1;
               if (last_idx) state_ff <= ST_VDROP;
            end
            ST_VDROP: begin
               idx_ff <= '0;
               if (!vfound_ff) state_ff <= ST_FREE;
               else begin
                  if (dirty_ff[vic_ff]) begin
                     push_now = 1'b1;
                     push_data_ff <= mk(EV_WRITEBACK, vic_ff, ttab_ff[vic_ff],
                                        tpage_ff[vic_ff], 1'b0);
                  end
                  valid_ff[vic_ff] <= 1'b0;
                  dirty_ff[vic_ff] <= 1'b0;
                  ref_rank_ff <= rank_ff[vic_ff];
                  occ_ff <= occ_ff - 1'b1;
                  adj_mode_ff <= 1'b1;
                  ret_ff <= ST_EVCHK;
                  state_ff <= ST_ADJ;
               end
            end
            ST_ADJ: begin
               // one slot per cycle: shift ranks; index wraps back to zero
               if (adj_mode_ff) begin
                  if (idx_ff == vic_ff) rank_ff[idx_ff] <= '0;
                  else if (valid_ff[idx_ff] && rank_ff[idx_ff] > ref_rank_ff)
                     rank_ff[idx_ff] <= rank_ff[idx_ff] - 1'b1;
               end else begin
                  if (idx_ff == vic_ff) rank_ff[idx_ff] <= '0;
                  else if (valid_ff[idx_ff] && rank_ff[idx_ff] < ref_rank_ff)
                     rank_ff[idx_ff] <= rank_ff[idx_ff] + 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               if (last_idx) begin
                  state_ff <= ret_ff;
                  if (ret_ff == ST_WAIT) push_now = 1'b1;
               end
            end
            ST_FREE: begin
               if (!valid_ff[idx_ff]) begin
                  vic_ff <= idx_ff;
                  state_ff <= ST_INS;
                  idx_ff <= '0;
               end else if (last_idx) begin
                  if (!out_busy) begin
                     push_now = 1'b1;
                     push_data_ff <= mk(EV_FULL, '0, tbl_ff, page_ff, 1'b1);
                     state_ff <= ST_WAIT;
                  end
               end else idx_ff <= idx_ff + 1'b1;
            end
            ST_INS: begin
               if (!out_busy) begin
                  valid_ff[vic_ff] <= 1'b1;
                  ttab_ff[vic_ff]  <= tbl_ff;
                  tpage_ff[vic_ff] <= page_ff;
                  occ_ff <= occ_ff + 1'b1;
                  if (kind_ff == KIND_FETCH) begin
                     pin_ff[vic_ff] <= PIN_BITS'(1);
                     dirty_ff[vic_ff] <= 1'b0;
                     push_data_ff <= mk(EV_LOAD, vic_ff, tbl_ff, page_ff, 1'b1);
                  end else begin
                     pin_ff[vic_ff] <= (kind_ff == KIND_NEW) ? PIN_BITS'(1) : '0;
                     dirty_ff[vic_ff] <= 1'b1;
                     push_data_ff <= mk(EV_DONE, vic_ff, tbl_ff, page_ff, 1'b1);
                  end
                  if ((kind_ff == KIND_FETCH && trans_ff) || kind_ff == KIND_PUSH) begin
                     rank_ff[vic_ff] <= SLOT_BITS'(occ_ff);
                     push_now = 1'b1;
                     state_ff <= ST_WAIT;
                  end else begin
                     // new page at MRU: rank pass moves every valid rank up,
                     // all of them sit below the all-ones mark
                     ref_rank_ff <= '1;
                     adj_mode_ff <= 1'b0;
                     ret_ff <= ST_WAIT;
                     state_ff <= ST_ADJ;
                  end
               end
            end
            ST_FSCAN: begin
               if (!out_busy) begin
                  if (valid_ff[idx_ff] && {1'b0, rank_ff[idx_ff]} == rscan_ff &&
                      dirty_ff[idx_ff] &&
                      (kind_ff == KIND_FLUSH_ALL || ttab_ff[idx_ff] == tbl_ff)) begin
                     push_now = 1'b1;
                     push_data_ff <= mk(EV_WRITEBACK, idx_ff, ttab_ff[idx_ff],
                                        tpage_ff[idx_ff], 1'b0);
                     dirty_ff[idx_ff] <= 1'b0;
                  end
                  idx_ff <= idx_ff + 1'b1;
                  if (last_idx) begin
                     rscan_ff <= rscan_ff + 1'b1;
                     if (rscan_ff + 1'b1 >= occ_ff) state_ff <= ST_EMIT_FINAL;
                  end
               end
            end
            ST_EMIT_FINAL: begin
               if (!out_busy) begin
                  push_now = 1'b1;
                  push_data_ff <= mk(EV_DONE, '0, tbl_ff, page_ff, 1'b1);
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (!out_busy) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      push_valid_ff <= push_now;
   end

   lpd_result_reg u_res (
      .clock(clock), .reset(reset), .push_valid(push_valid_ff),
      .push_data(push_data_ff), .full(full), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_data(rsp_data)
   );

   assign rsp_tdata = {4'b0000, rsp_data.out_page, rsp_data.out_table, rsp_data.slot};
   assign rsp_tuser = rsp_data.event_res;
   assign rsp_tlast = rsp_data.last;

   `LPD_ASSERT_IMPL(a_occ_range, clock, reset, occ_ff <= CNT_BITS'(CAPACITY))
   `LPD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `LPD_ASSERT_IMPL(a_occ_count, clock, reset, occ_ff == CNT_BITS'($countones(valid_ff)))
   `LPD_ASSERT_IMPL(a_no_overwrite, clock, reset, !(push_valid_ff && full))
endmodule

### tb/sv/lru_pinned_page_directory_checker.sv
// Checker for the page directory: tracks pool state from observed request and
// register transactions, predicts results and compares each response.
// Depends on lpd_pkg.
module lru_pinned_page_directory_checker
   import lpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [4:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [4:0]  csr_data,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [PIN_BITS-1:0] PIN_FULL = '1;

   // shadow pool
   logic                 live [CAPACITY];
   logic [7:0]           tbl_tag [CAPACITY];
   logic [31:0]          page_tag [CAPACITY];
   logic [PIN_BITS-1:0]  pins [CAPACITY];
   logic                 dirty [CAPACITY];
   int                   rank [CAPACITY];
   int                   in_use;
   logic [4:0]           limit_reg;
   result_type           awaited_results [$];

   assign pending_count = awaited_results.size();

   function automatic void post(event_type ev, int s, logic [7:0] t, logic [31:0] p);
      result_type r;
      r.event_res = ev;
      r.slot = s[3:0];
      r.out_table = t;
      r.out_page = p;
      r.last = 1'b0;
      awaited_results = {awaited_results, r};
   endfunction

   function automatic int find_page(logic [7:0] t, logic [31:0] p);
      for (int i = 0; i < CAPACITY; i++)
         if (live[i] && tbl_tag[i] == t && page_tag[i] == p) return i;
      return -1;
   endfunction

   function automatic int active_limit();
      if (limit_reg == 0) return 1;
      if (limit_reg > CAPACITY) return CAPACITY;
      return limit_reg;
   endfunction

   // drop least recent unpinned slots until under the limit or none is left
   function automatic void make_room();
      int v;
      while (in_use >= active_limit()) begin
         v = -1;
         for (int i = 0; i < CAPACITY; i++)
            if (live[i] && pins[i] == 0 && (v < 0 || rank[i] > rank[v])) v = i;
         if (v < 0) break;
         if (dirty[v]) post(EV_WRITEBACK, v, tbl_tag[v], page_tag[v]);
         live[v] = 1'b0;
         for (int i = 0; i < CAPACITY; i++)
            if (live[i] && rank[i] > rank[v]) rank[i]--;
         pins[v] = '0;
         dirty[v] = 1'b0;
         rank[v] = 0;
         in_use--;
      end
   endfunction

   function automatic int place(logic [7:0] t, logic [31:0] p, int pin_init,
                                logic dirt, logic at_tail);
      int s;
      s = -1;
      for (int i = 0; i < CAPACITY; i++)
         if (!live[i]) begin
            s = i;
            break;
         end
      if (s < 0) return -1;
      if (at_tail) begin
         rank[s] = in_use;
      end else begin
         for (int i = 0; i < CAPACITY; i++) if (live[i]) rank[i]++;
         rank[s] = 0;
      end
      live[s] = 1'b1;
      tbl_tag[s] = t;
      page_tag[s] = p;
      pins[s] = pin_init[PIN_BITS-1:0];
      dirty[s] = dirt;
      in_use++;
      return s;
   endfunction

   function automatic void write_back(logic all, logic [7:0] t);
      for (int r = 0; r < in_use; r++)
         for (int i = 0; i < CAPACITY; i++)
            if (live[i] && rank[i] == r && dirty[i] && (all || tbl_tag[i] == t)) begin
               post(EV_WRITEBACK, i, tbl_tag[i], page_tag[i]);
               dirty[i] = 1'b0;
            end
   endfunction

   // expected results of one request
   function automatic void predict_request(logic [2:0] kind, logic [7:0] t,
                                           logic [31:0] p, logic transient,
                                           logic mark);
      int s;
      int r;
      s = find_page(t, p);
      case (kind)
         KIND_FETCH: begin
            if (s >= 0) begin
               if (pins[s] != PIN_FULL) pins[s]++;
               if (!transient) begin
                  r = rank[s];
                  for (int i = 0; i < CAPACITY; i++)
                     if (live[i] && rank[i] < r) rank[i]++;
                  rank[s] = 0;
               end
               post(EV_HIT, s, t, p);
            end else begin
               make_room();
               s = place(t, p, 1, 1'b0, transient);
               if (s < 0) post(EV_FULL, 0, t, p);
               else post(EV_LOAD, s, t, p);
            end
         end
         KIND_NEW: begin
            if (s >= 0) begin
               post(EV_EXISTS, s, t, p);
            end else begin
               make_room();
               s = place(t, p, 1, 1'b1, 1'b0);
               if (s < 0) post(EV_FULL, 0, t, p);
               else post(EV_DONE, s, t, p);
            end
         end
         KIND_UNPIN: begin
            if (s >= 0) begin
               if (pins[s] != 0) pins[s]--;
               if (mark) dirty[s] = 1'b1;
               post(EV_DONE, s, t, p);
            end else begin
               post(EV_NOT_FOUND, 0, t, p);
            end
         end
         KIND_PUSH: begin
            if (s >= 0) begin
               dirty[s] = 1'b1;
               post(EV_DONE, s, t, p);
            end else begin
               make_room();
               s = place(t, p, 0, 1'b1, 1'b1);
               if (s < 0) post(EV_FULL, 0, t, p);
               else post(EV_DONE, s, t, p);
            end
         end
         KIND_FLUSH_TBL: begin
            write_back(1'b0, t);
            post(EV_DONE, 0, t, p);
         end
         KIND_FLUSH_ALL: begin
            write_back(1'b1, t);
            post(EV_DONE, 0, t, p);
         end
         default: post(EV_DONE, 0, t, p);
      endcase
      awaited_results[$].last = 1'b1;
   endfunction

   // watch the three channels
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            live[i] <= 1'b0;
            pins[i] <= '0;
            dirty[i] <= 1'b0;
            rank[i] <= 0;
         end
         in_use <= 0;
         limit_reg <= 5'd16;
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_tvalid && req_tready)
            predict_request(req_tuser[2:0], req_tdata[7:0], req_tdata[39:8],
                            req_tuser[3], req_tuser[4]);
         if (rsp_tvalid && rsp_tready) begin
            seen.event_res = rsp_tuser;
            seen.slot = rsp_tdata[3:0];
            seen.out_table = rsp_tdata[11:4];
            seen.out_page = rsp_tdata[43:12];
            seen.last = rsp_tlast;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $realtime, seen);
               error_count <= error_count + 1;
            end else begin
               want = awaited_results.pop_front();
               if (seen.event_res != want.event_res || seen.slot != want.slot ||
                   seen.out_table != want.out_table || seen.out_page != want.out_page ||
                   seen.last != want.last) begin
                  $display("%0t: mismatch expected ev=%0d slot=%0d tbl=%h page=%h last=%b",
                           $realtime, want.event_res, want.slot, want.out_table,
                           want.out_page, want.last);
                  $display("%0t:          actual   ev=%0d slot=%0d tbl=%h page=%h last=%b",
                           $realtime, seen.event_res, seen.slot, seen.out_table,
                           seen.out_page, seen.last);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/sv/lru_pinned_page_directory_test.sv
// Top of the page directory testbench: clock, reset, request and register
// stimulus, response back-pressure and the verdict.
// Depends on lpd_pkg, lru_pinned_page_directory and its checker.
module lru_pinned_page_directory_test
   import lpd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;
   int          error_count;
   int          pending_count;
   logic        steady = 1'b0;

   localparam logic [31:0] PAGE_TOP = '1;

   always #6 clock = ~clock;

   lru_pinned_page_directory dut (.*);

   lru_pinned_page_directory_checker watcher (.*);

   // response back-pressure
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 22);

   task automatic send_request(logic [2:0] kind, logic [7:0] t, logic [31:0] p,
                               logic transient, logic mark);
      if (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata <= {p, t};
      req_tuser <= {mark, transient, kind};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // wait for the pool to go quiet, then write the limit
   task automatic set_limit(logic [4:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random request over a small tag set so hits, pins and evictions happen
   task automatic random_request();
      int          pick;
      logic [2:0]  kind;
      logic [7:0]  t;
      logic [31:0] p;
      pick = $urandom_range(99);
      if (pick < 36) kind = KIND_FETCH;
      else if (pick < 62) kind = KIND_UNPIN;
      else if (pick < 74) kind = KIND_NEW;
      else if (pick < 86) kind = KIND_PUSH;
      else if (pick < 92) kind = KIND_FLUSH_TBL;
      else if (pick < 97) kind = KIND_FLUSH_ALL;
      else kind = 3'($urandom_range(6, 7));
      case ($urandom_range(3))
         0: t = 8'h00;
         1: t = 8'hff;
         default: t = 8'($urandom_range(1, 3));
      endcase
      if ($urandom_range(9) == 0) p = $urandom();
      else if ($urandom_range(9) == 0) p = PAGE_TOP;
      else p = 32'($urandom_range(0, 9));
      send_request(kind, t, p, 1'($urandom()), 1'($urandom()));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening
      send_request(KIND_FETCH, 8'h00, 32'd0, 1'b0, 1'b0);
      send_request(KIND_FETCH, 8'hff, PAGE_TOP, 1'b0, 1'b0);
      send_request(KIND_FETCH, 8'h00, 32'd0, 1'b1, 1'b0);
      send_request(KIND_FETCH, 8'h55, 32'haaaa_aaaa, 1'b1, 1'b0);
      send_request(KIND_FETCH, 8'haa, 32'h5555_5555, 1'b0, 1'b1);
      send_request(KIND_NEW, 8'h10, 32'd5, 1'b0, 1'b0);
      send_request(KIND_NEW, 8'h10, 32'd5, 1'b0, 1'b0);
      send_request(KIND_UNPIN, 8'h00, 32'd0, 1'b0, 1'b1);
      send_request(KIND_UNPIN, 8'h00, 32'd0, 1'b0, 1'b0);
      send_request(KIND_UNPIN, 8'h00, 32'd0, 1'b0, 1'b0);
      send_request(KIND_UNPIN, 8'h77, 32'd9, 1'b0, 1'b1);
      send_request(KIND_PUSH, 8'hff, PAGE_TOP, 1'b0, 1'b0);
      send_request(KIND_PUSH, 8'h20, 32'd7, 1'b1, 1'b1);
      send_request(KIND_FLUSH_TBL, 8'hff, 32'd0, 1'b0, 1'b0);
      send_request(KIND_FLUSH_ALL, 8'h00, PAGE_TOP, 1'b0, 1'b0);
      send_request(3'd6, 8'h01, 32'd1, 1'b0, 1'b0);
      send_request(3'd7, 8'h02, 32'd2, 1'b1, 1'b1);

      // tight pool, then all pinned
      set_limit(5'd1);
      for (int i = 0; i < 20; i++) send_request(KIND_FETCH, 8'h30, 32'(i), 1'b0, 1'b0);
      send_request(KIND_NEW, 8'h31, 32'd1, 1'b0, 1'b0);
      send_request(KIND_PUSH, 8'h31, 32'd2, 1'b0, 1'b0);
      for (int i = 0; i < 16; i++) send_request(KIND_UNPIN, 8'h30, 32'(i), 1'b0, 1'b1);

      // random phases across settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_limit(5'd16);
            1: set_limit(5'd3);
            2: set_limit(5'd31);
            3: set_limit(5'd0);
            4: set_limit(5'd8);
            default: set_limit(5'd1);
         endcase
         steady <= (ph == 2);
         for (int i = 0; i < 70; i++) random_request();
      end

      req_tvalid <= 1'b0;
      steady <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

### lru_pinned_page_directory.f
+incdir+hdl
hdl/lpd_pkg.sv
hdl/lpd_result_reg.sv
hdl/lru_pinned_page_directory.sv
tb/sv/lru_pinned_page_directory_checker.sv
tb/sv/lru_pinned_page_directory_test.sv
